/* src/u8u16_pkg.sv */
// Shared types, constants and helpers of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
package u8u16_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;

	localparam logic [2:0] LEN_BAD   = 3'd0;
	localparam logic [2:0] LEN_ASCII = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_UNIT,
		TAIL_PAIR
	} tail_t;

	typedef struct packed {
		logic [1:0]  fffd_cnt;
		tail_t       tail;
		logic [20:0] value;
	} cmd_t;

	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0)
			len = LEN_ASCII;
		else if (b[7:5] == 3'b110)
			len = LEN_TWO;
		else if (b[7:4] == 4'b1110)
			len = LEN_THREE;
		else if (b[7:3] == 5'b11110)
			len = LEN_FOUR;
		else
			len = LEN_BAD;
		return len;
	endfunction

endpackage

/* src/u8u16_byte_if.sv */
// Byte channel: one UTF-8 byte with its end-of-text flag.
`timescale 1ns / 1ps
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* src/u8u16_unit_if.sv */
// Unit channel: one UTF-16 code unit with its run-last flag.
`timescale 1ns / 1ps
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        run_last;

	modport source (output valid, output code_unit, output run_last, input ready);
	modport sink (input valid, input code_unit, input run_last, output ready);
endinterface

/* src/utf8_to_utf16_transcoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder.
// Takes one UTF-8 byte per request on text and gives UTF-16 code units on units, with
// run_last set on the last unit that a byte causes; malformed, broken or cut-off sequences
// give U+FFFD units, and code points above U+FFFF give a surrogate pair. A byte is taken
// every cycle while the four-entry command queue has room; the back end gives a command's
// code units one at a time, so a surrogate pair or a burst of replacement units keeps its
// command at the queue head until its last unit goes, throttling input only when the queue fills.
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_byte_if.sink   text,
	u8u16_unit_if.source units
);
	import u8u16_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	u8u16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	u8u16_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.units      (units)
	);

endmodule

/* src/u8u16_front.sv */
// Front end: decodes each byte against the open sequence and issues unit commands.
`timescale 1ns / 1ps
module u8u16_front (
	input  logic           clk,
	input  logic           arst_n,
	u8u16_byte_if.sink     text,
	input  logic           full,
	output logic           push,
	output u8u16_pkg::cmd_t push_cmd
);
	import u8u16_pkg::*;

	logic [2:0]  exp_q;
	logic [1:0]  held_q;
	logic [20:0] partial_q;

	logic [2:0]  exp_d;
	logic [1:0]  held_d;
	logic [20:0] partial_d;

	logic [7:0]  b;
	logic        eot;
	logic        accept;
	logic        is_cont;
	logic [2:0]  lead_len;
	tail_t       lead_tail;
	logic [20:0] lead_value;
	logic        lead_opens;
	logic [20:0] lead_partial;
	logic [1:0]  held_new;
	logic [20:0] partial_new;
	logic        complete;
	cmd_t        cmd;

	assign b          = text.text_byte;
	assign eot        = text.end_of_text;
	assign text.ready = !full;
	assign accept     = text.valid && !full;
	assign is_cont    = (b[7:6] == 2'b10);
	assign lead_len   = seq_len(b);

	always_comb begin
		lead_tail    = TAIL_NONE;
		lead_value   = {5'd0, REPLACEMENT};
		lead_opens   = 1'b0;
		lead_partial = '0;
		unique case (lead_len)
			LEN_BAD: begin
				lead_tail = TAIL_UNIT;
			end
			LEN_ASCII: begin
				lead_tail  = TAIL_UNIT;
				lead_value = {13'd0, b};
			end
			LEN_TWO, LEN_THREE, LEN_FOUR: begin
				if (eot) begin
					lead_tail = TAIL_UNIT;
				end else begin
					lead_opens = 1'b1;
				end
				if (lead_len == LEN_TWO)
					lead_partial = {16'd0, b[4:0]};
				else if (lead_len == LEN_THREE)
					lead_partial = {17'd0, b[3:0]};
				else
					lead_partial = {18'd0, b[2:0]};
			end
			default: begin
				lead_tail = TAIL_UNIT;
			end
		endcase
	end

	assign held_new    = held_q + 2'd1;
	assign partial_new = {partial_q[14:0], b[5:0]};
	assign complete    = (({1'b0, held_new} + 3'd1) >= exp_q);

	always_comb begin
		cmd       = '{fffd_cnt: 2'd0, tail: TAIL_NONE, value: '0};
		exp_d     = exp_q;
		held_d    = held_q;
		partial_d = partial_q;
		if (exp_q != 3'd0 && is_cont) begin
			exp_d     = '0;
			held_d    = '0;
			partial_d = '0;
			if (complete) begin
				cmd.value = partial_new;
				cmd.tail  = (partial_new[20:16] == 5'd0) ? TAIL_UNIT : TAIL_PAIR;
			end else if (eot) begin
				cmd.fffd_cnt = held_new + 2'd1;
			end else begin
				exp_d     = exp_q;
				held_d    = held_new;
				partial_d = partial_new;
			end
		end else begin
			if (exp_q != 3'd0)
				cmd.fffd_cnt = held_q + 2'd1;
			cmd.tail  = lead_tail;
			cmd.value = lead_value;
			if (lead_opens) begin
				exp_d     = lead_len;
				held_d    = '0;
				partial_d = lead_partial;
			end else begin
				exp_d     = '0;
				held_d    = '0;
				partial_d = '0;
			end
		end
	end

	assign push     = accept && (cmd.fffd_cnt != 2'd0 || cmd.tail != TAIL_NONE);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= '0;
			held_q    <= '0;
			partial_q <= '0;
		end else if (accept) begin
			exp_q     <= exp_d;
			held_q    <= held_d;
			partial_q <= partial_d;
		end
	end

endmodule

/* src/u8u16_queue.sv */
// Command queue between the decode front end and the unit back end.
`timescale 1ns / 1ps
module u8u16_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u8u16_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output u8u16_pkg::cmd_t head_cmd
);
	import u8u16_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

/* src/u8u16_back.sv */
// Back end: puts each command's code units in an output register, one per unstalled cycle.
`timescale 1ns / 1ps
module u8u16_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  u8u16_pkg::cmd_t head_cmd,
	output logic            pop,
	u8u16_unit_if.source    units
);
	import u8u16_pkg::*;

	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [15:0] out_unit_q;
	logic        out_last_q;

	logic [2:0]  tail_cnt;
	logic [2:0]  total;
	logic [2:0]  tail_idx;
	logic [20:0] offset;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	logic [15:0] unit;
	logic        last;
	logic        load;

	always_comb begin
		case (head_cmd.tail)
			TAIL_UNIT: tail_cnt = 3'd1;
			TAIL_PAIR: tail_cnt = 3'd2;
			default:   tail_cnt = 3'd0;
		endcase
	end

	assign total    = {1'b0, head_cmd.fffd_cnt} + tail_cnt;
	assign tail_idx = idx_q - {1'b0, head_cmd.fffd_cnt};
	assign offset   = head_cmd.value - SUPP_BASE;
	assign hi_unit  = HI_SURR + {5'd0, offset[20:10]};
	assign lo_unit  = LO_SURR | {6'd0, offset[9:0]};
	assign last     = (idx_q == total - 3'd1);

	always_comb begin
		if (idx_q < {1'b0, head_cmd.fffd_cnt})
			unit = REPLACEMENT;
		else if (head_cmd.tail == TAIL_PAIR)
			unit = (tail_idx == 3'd0) ? hi_unit : lo_unit;
		else
			unit = head_cmd.value[15:0];
	end

	assign load = head_valid && (!out_valid_q || units.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
			end else if (units.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_unit_q <= unit;
			out_last_q <= last;
		end
	end

	assign units.valid     = out_valid_q;
	assign units.code_unit = out_unit_q;
	assign units.run_last  = out_last_q;

endmodule
